[rtl/hla_pkg.sv]
// Package for the Hough line accumulator: field widths, action and register codes,
// the quarter-wave Q1.14 sine table and the vote item struct.
// No dependencies.
package hla_pkg;

	localparam int MAX_SIDE_DEF    = 128;
	localparam int RHO_BINS_DEF    = 256;
	localparam int ANGLE_STEPS_DEF = 360;

	localparam int ANGLE_W   = 9;   // angle_index width, angles up to 359
	localparam int RHO_MAX_W = 11;  // holds any rho bin up to 2047
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W   = 15;
	localparam int ACTION_W  = 2;
	localparam int PIXEL_W   = 8;
	localparam int TRIG_W    = 16;  // signed Q1.14, magnitude up to 16384
	localparam int FRAC_W    = 14;
	localparam int QUARTER   = 90;
	localparam int QIDX_W    = 7;   // indexes 0..90

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [PIXEL_W-1:0] EDGE_LEVEL  = '1;
	localparam logic [CFG_W-1:0]   SIDE_RESET  = 8'd128;

	typedef enum logic [ACTION_W-1:0] {
		ACT_VOTE     = 2'd0,
		ACT_READ     = 2'd1,
		ACT_READ_CLR = 2'd2,
		ACT_NOP      = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ROWS = 1'b0,
		REG_IMAGE_COLS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                 valid;
		logic [ANGLE_W-1:0]   theta;
		logic [RHO_MAX_W-1:0] rho;
	} vote_t;

	typedef logic [FRAC_W:0] qsine_tab_t [0:QUARTER];

	localparam logic [63:0] ROT_COS = 64'd1073578288;
	localparam logic [63:0] ROT_SIN = 64'd18739379;

	// Rotate a Q30 unit vector one degree per step; round every step and the final
	// value to Q14.
	function automatic qsine_tab_t build_qsine();
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] nc;
		logic [63:0] ns;
		logic [63:0] v;
		logic [63:0] cs [0:45];
		logic [63:0] ss [0:45];
		qsine_tab_t  t;
		c = 64'd1 << 30;
		s = 64'd0;
		for (int d = 0; d <= 45; d++) begin
			cs[d] = c;
			ss[d] = s;
			nc = (c * ROT_COS - s * ROT_SIN + (64'd1 << 29)) >> 30;
			ns = (s * ROT_COS + c * ROT_SIN + (64'd1 << 29)) >> 30;
			c = nc;
			s = ns;
		end
		for (int d = 0; d <= QUARTER; d++) begin
			v = (d <= 45) ? ss[d] : cs[QUARTER - d];
			t[d] = (FRAC_W + 1)'((v + (64'd1 << 15)) >> 16);
		end
		return t;
	endfunction

	localparam qsine_tab_t QSINE = build_qsine();

	// Signed sine of (quadrant, remainder) by quarter-wave symmetry.
	function automatic logic signed [TRIG_W-1:0] qsine_lookup(
		input logic [1:0]        quad,
		input logic [QIDX_W-1:0] rem
	);
		logic [FRAC_W:0]          mag;
		logic signed [TRIG_W-1:0] val;
		mag = quad[0] ? QSINE[QIDX_W'(QUARTER) - rem] : QSINE[rem];
		val = $signed({1'b0, mag});
		return quad[1] ? -val : val;
	endfunction

endpackage

[rtl/hla_acc_ram.sv]
// Accumulator memory: one write port, one read port, registered read data.
// No dependencies.
module hla_acc_ram #(
	parameter int DEPTH  = 92160,
	parameter int ADDR_W = 17,
	parameter int DATA_W = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/hla_vote_gen.sv]
// Vote generator: steps theta over all angles for one pixel and computes the rho bin
// in a three-stage pipeline (trig lookup, products, sum and range check).
// Depends on hla_pkg.
module hla_vote_gen
	import hla_pkg::*;
#(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int RHO_BINS    = RHO_BINS_DEF,
	parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [$clog2(MAX_SIDE)-1:0] x,
	input  logic [$clog2(MAX_SIDE)-1:0] y,
	output vote_t                       vote,
	output logic                        busy
);

	localparam int CW  = $clog2(MAX_SIDE);
	localparam int PW  = CW + 1 + TRIG_W;
	localparam int SW  = PW + 1;
	localparam int RFW = SW - 1 - FRAC_W;

	logic                     run_q;
	logic [ANGLE_W-1:0]       theta_q;
	logic [1:0]               quad_q;
	logic [QIDX_W-1:0]        rem_q;
	logic [CW-1:0]            x_q;
	logic [CW-1:0]            y_q;

	logic                     valid_s1;
	logic [ANGLE_W-1:0]       theta_s1;
	logic signed [TRIG_W-1:0] sin_s1;
	logic signed [TRIG_W-1:0] cos_s1;

	logic                     valid_s2;
	logic [ANGLE_W-1:0]       theta_s2;
	logic signed [PW-1:0]     px_s2;
	logic signed [PW-1:0]     py_s2;

	logic                     valid_s3;
	logic [ANGLE_W-1:0]       theta_s3;
	logic [RHO_MAX_W-1:0]     rho_s3;

	logic signed [SW-1:0]     sum;
	logic [RFW-1:0]           rho_full;

	// theta sequencer; quadrant and remainder track theta so no divide by 90
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			theta_q <= '0;
			quad_q  <= '0;
			rem_q   <= '0;
		end else if (start) begin
			run_q   <= 1'b1;
			theta_q <= '0;
			quad_q  <= '0;
			rem_q   <= '0;
		end else if (run_q) begin
			theta_q <= theta_q + 1'b1;
			if (rem_q == QIDX_W'(QUARTER - 1)) begin
				rem_q  <= '0;
				quad_q <= quad_q + 1'b1;
			end else begin
				rem_q <= rem_q + 1'b1;
			end
			if (theta_q == ANGLE_W'(ANGLE_STEPS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= run_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && !sum[SW-1] && (32'(rho_full) < RHO_BINS);
		end
	end

	// cos(theta) is sin of the next quadrant at the same remainder
	always_ff @(posedge clk) begin
		theta_s1 <= theta_q;
		sin_s1   <= qsine_lookup(quad_q, rem_q);
		cos_s1   <= qsine_lookup(quad_q + 2'd1, rem_q);
		theta_s2 <= theta_s1;
		px_s2    <= $signed({1'b0, x_q}) * cos_s1;
		py_s2    <= $signed({1'b0, y_q}) * sin_s1;
		theta_s3 <= theta_s2;
		rho_s3   <= RHO_MAX_W'(rho_full);
	end

	// truncate toward zero; only non-negative sums are used
	assign sum      = SW'(px_s2) + SW'(py_s2);
	assign rho_full = sum[SW-2:FRAC_W];

	assign vote = '{valid: valid_s3, theta: theta_s3, rho: rho_s3};
	assign busy = run_q || valid_s1 || valid_s2 || valid_s3;

endmodule

[rtl/hough_line_accumulator.sv]
// Top level of the Hough line accumulator: control, clearing pass, read-modify-write
// of the vote memory and the result register.
// Depends on hla_pkg, hla_vote_gen and hla_acc_ram.
//
// Channel  Direction  Handshake             Payload
// in       to block   in_valid/in_ready     action, pixel_col, pixel_row, pixel_value,
//                                           angle_index, rho_index
// out      from block out_valid/out_ready   bin_count
// cfg      to block   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A vote item holds the input until its last vote has left the pipeline: the theta
// sequencer issues one angle a cycle and each angle costs one read and one write of
// the single accumulator RAM. A vote item that does not count (wrong gray level or
// outside the image) and the unused action are taken without leaving idle. A read
// item passes through the read state for the registered RAM read. After reset the
// block sweeps all ANGLE_STEPS * 2**clog2(RHO_BINS) bins (92160 at the defaults) to
// zero, one bin a cycle, and takes no item until the sweep ends; configuration writes
// are taken at any time.
// Vote items keep flowing while a result waits on out_ready; a read item waits only
// until the result register is free.
module hough_line_accumulator
	import hla_pkg::*;
#(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int RHO_BINS    = RHO_BINS_DEF,
	parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ACTION_W-1:0]         action,
	input  logic [$clog2(MAX_SIDE)-1:0] pixel_col,
	input  logic [$clog2(MAX_SIDE)-1:0] pixel_row,
	input  logic [PIXEL_W-1:0]          pixel_value,
	input  logic [ANGLE_W-1:0]          angle_index,
	input  logic [$clog2(RHO_BINS)-1:0] rho_index,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [COUNT_W-1:0]          bin_count,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	localparam int CW     = $clog2(MAX_SIDE);
	localparam int RW     = $clog2(RHO_BINS);
	localparam int DEPTH  = ANGLE_STEPS * (1 << RW);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMPW   = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_VOTE  = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    clr_q;
	logic [CFG_W-1:0]     image_rows_q;
	logic [CFG_W-1:0]     image_cols_q;

	logic                 rd_clear_q;
	logic                 rd_oor_q;
	logic [ADDR_W-1:0]    rd_addr_q;

	logic                 wb_valid_s4;
	logic [ADDR_W-1:0]    wb_addr_s4;

	logic                 out_valid_q;
	logic [COUNT_W-1:0]   bin_count_q;

	logic                 accept;
	logic                 is_read;
	logic                 out_free;
	logic                 pixel_ok;
	logic                 read_in_range;
	logic [ADDR_W-1:0]    read_addr;
	logic                 gen_start;
	vote_t                vote;
	logic                 gen_busy;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [COUNT_W-1:0]   ram_wdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [COUNT_W-1:0]   ram_rdata;

	// ---------------- input decode ----------------
	assign is_read  = (action == ACT_READ) || (action == ACT_READ_CLR);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && (!is_read || out_free);
	assign accept   = in_valid && in_ready;

	// a vote counts only for a full-white pixel inside the configured image
	assign pixel_ok = (pixel_value == EDGE_LEVEL)
		&& (CMPW'(pixel_col) < CMPW'(image_cols_q))
		&& (CMPW'(pixel_row) < CMPW'(image_rows_q));

	assign read_in_range = (32'(angle_index) < ANGLE_STEPS) && (32'(rho_index) < RHO_BINS);
	assign read_addr     = ADDR_W'({angle_index, rho_index});
	assign gen_start     = accept && (action == ACT_VOTE) && pixel_ok;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= SIDE_RESET;
			image_cols_q <= SIDE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_ROWS: image_rows_q <= cfg_data;
				REG_IMAGE_COLS: image_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					// sweep every bin to zero, then open the input
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (gen_start) begin
						state_q <= ST_VOTE;
					end else if (accept && is_read) begin
						state_q <= ST_READ;
					end
				end
				ST_VOTE: begin
					// hold until the last vote has left the pipeline
					if (!gen_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_clear_q <= (action == ACT_READ_CLR);
			rd_oor_q   <= !read_in_range;
			rd_addr_q  <= read_addr;
		end
		wb_addr_s4 <= ADDR_W'({vote.theta, vote.rho[RW-1:0]});
	end

	// write-back stage: registered from the vote's RAM read, in the cycle after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_s4 <= 1'b0;
		end else begin
			wb_valid_s4 <= vote.valid;
		end
	end

	// ---------------- vote generator ----------------
	hla_vote_gen #(
		.MAX_SIDE   (MAX_SIDE),
		.RHO_BINS   (RHO_BINS),
		.ANGLE_STEPS(ANGLE_STEPS)
	) u_vote_gen (
		.clk   (clk),
		.arst_n(arst_n),
		.start (gen_start),
		.x     (pixel_col),
		.y     (pixel_row),
		.vote  (vote),
		.busy  (gen_busy)
	);

	// ---------------- accumulator RAM ports ----------------
	// Successive angles hit different rows, so a read never meets a pending write
	// to the same bin; pixels do not overlap because a new item waits for the drain.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = wb_addr_s4;
		if (accept && is_read && read_in_range) begin
			ram_re    = 1'b1;
			ram_raddr = read_addr;
		end else if (vote.valid) begin
			ram_re    = 1'b1;
			ram_raddr = ADDR_W'({vote.theta, vote.rho[RW-1:0]});
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wb_addr_s4;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (wb_valid_s4) begin
			// saturate at full count
			ram_we    = 1'b1;
			ram_waddr = wb_addr_s4;
			ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
		end else if ((state_q == ST_READ) && rd_clear_q && !rd_oor_q) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_q;
		end
	end

	hla_acc_ram #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(COUNT_W)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			bin_count_q <= rd_oor_q ? '0 : ram_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_count = bin_count_q;

	// ---------------- assertions ----------------
	a_vote_only_in_vote: assert property (@(posedge clk) disable iff (!arst_n)
		vote.valid |-> (state_q == ST_VOTE))
		else $error("vote issued outside the vote phase");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !out_valid_q)
		else $error("read result would overwrite a pending result");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_READ))
		else $error("result raised without a read");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!in_ready && !vote.valid))
		else $error("item taken during the clearing pass");

endmodule
